// ===== hdl/csvtok_pkg.sv =====
// Shared types, character codes and register indexes of the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvtok_pkg;

  // Default saturation limit of the cell counters.
  localparam int unsigned MAX_COLUMNS_DEF = 1023;

  // Fixed field widths.
  localparam int unsigned CU_W  = 16;
  localparam int unsigned CNT_OUT_W = 10;

  // Special code units.
  localparam logic [CU_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CU_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CU_W-1:0] CH_LF    = 16'h000A;

  // Configuration register defaults.
  localparam logic [CU_W-1:0] DELIMITER_RST    = 16'd44;
  localparam logic [CU_W-1:0] COMMENT_CHAR_RST = 16'd35;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DELIMITER    = 2'd0,
    CFG_COMMENT_EN   = 2'd1,
    CFG_COMMENT_CHAR = 2'd2
  } cfg_idx_t;

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_t;

  // Parser state, one-hot.
  typedef enum logic [6:0] {
    M_ROW_START   = 7'b0000001,
    M_AFTER_CR    = 7'b0000010,
    M_FIELD_START = 7'b0000100,
    M_PLAIN       = 7'b0001000,
    M_QUOTED      = 7'b0010000,
    M_QUOTE_SEEN  = 7'b0100000,
    M_COMMENT     = 7'b1000000
  } mode_t;

  // What one code unit makes the parser emit.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DATA,
    ACT_FIELD,
    ACT_ROW
  } act_t;

  // One result transaction as held in the output buffer.
  typedef struct packed {
    kind_t                 kind;
    logic [CU_W-1:0]       data_char;
    logic                  comment;
    logic [CNT_OUT_W-1:0]  cells;
    logic [CNT_OUT_W-1:0]  max_cols;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/csv_field_tokenizer_core.sv =====
// Top level of the streaming CSV field tokenizer.
// A result passes through the input register and then the output buffer on its way out.
// Throughput: one input transaction per cycle while the output buffer can take it; an input
// that ends a row gives two results, which leave the single output port one after the other.
// An input register feeds the parser, whose results land in a two-entry output buffer.
// Reset: synchronous, active low; clears the parser state and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer_core #(
  parameter int unsigned MAX_COLUMNS = csvtok_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tuser,   // [0] cmd (1 = end-of-input flush)
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] data_char, [25:16] cells_in_row,
                                       // [35:26] max_columns, [39:36] zero
  output logic [2:0]       out_tuser,  // [1:0] kind, [2] comment_row
  output logic             out_tlast,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMNS);

  // Configuration registers.
  logic [15:0] delimiter_r;
  logic        comment_en_r;
  logic [15:0] comment_char_r;

  // Input register.
  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [15:0] s1_cu_r;

  // Parser state.
  csvtok_pkg::mode_t mode_r, mode_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;

  // Output buffer.
  csvtok_pkg::res_t ob0_r, ob1_r;
  logic [1:0]       ob_cnt_r;

  // Parser results for the item in the input register.
  csvtok_pkg::res_t r0, r1;
  logic [1:0]       n_res;

  logic out_take;
  logic ob_free;
  logic s1_adv;

  // Configuration writes; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r    <= csvtok_pkg::DELIMITER_RST;
      comment_en_r   <= 1'b0;
      comment_char_r <= csvtok_pkg::COMMENT_CHAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csvtok_pkg::CFG_DELIMITER:    delimiter_r    <= cfg_data;
        csvtok_pkg::CFG_COMMENT_EN:   comment_en_r   <= cfg_data[0];
        csvtok_pkg::CFG_COMMENT_CHAR: comment_char_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the output buffer will be empty.
  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign out_take   = out_tvalid && out_tready;
  assign ob_free    = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && out_take);
  assign s1_adv     = s1_valid_r && ob_free;
  assign in_tready  = !s1_valid_r || ob_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_cu_r  <= in_tdata;
    end
  end

  // Parser decision and result formation.
  always_comb begin
    logic              is_q, is_dl, is_cr, is_brk, is_cm;
    csvtok_pkg::act_t  pl_act, fs_act, rs_act, act;
    csvtok_pkg::mode_t pl_mode, fs_mode, rs_mode, brk_mode;
    logic              rs_comm, comm;
    logic [CNT_W-1:0]  cnt_inc, col_row;

    is_q     = (s1_cu_r == csvtok_pkg::CH_QUOTE);
    is_dl    = (s1_cu_r == delimiter_r);
    is_cr    = (s1_cu_r == csvtok_pkg::CH_CR);
    is_brk   = is_cr || (s1_cu_r == csvtok_pkg::CH_LF);
    is_cm    = comment_en_r && (s1_cu_r == comment_char_r);
    brk_mode = is_cr ? csvtok_pkg::M_AFTER_CR : csvtok_pkg::M_ROW_START;

    // Unit inside an unquoted field.
    if (is_dl) begin
      pl_act  = csvtok_pkg::ACT_FIELD;
      pl_mode = csvtok_pkg::M_FIELD_START;
    end else if (is_brk) begin
      pl_act  = csvtok_pkg::ACT_ROW;
      pl_mode = brk_mode;
    end else begin
      pl_act  = csvtok_pkg::ACT_DATA;
      pl_mode = csvtok_pkg::M_PLAIN;
    end

    // Unit at the start of a field: a quote opens a quoted field.
    if (is_q) begin
      fs_act  = csvtok_pkg::ACT_NONE;
      fs_mode = csvtok_pkg::M_QUOTED;
    end else begin
      fs_act  = pl_act;
      fs_mode = pl_mode;
    end

    // Unit at the start of a row: comment check, then blank line, then field start.
    rs_comm = 1'b0;
    if (is_cm) begin
      rs_act  = csvtok_pkg::ACT_DATA;
      rs_mode = csvtok_pkg::M_COMMENT;
      rs_comm = 1'b1;
    end else if (!is_q && !is_dl && is_brk) begin
      rs_act  = csvtok_pkg::ACT_NONE;
      rs_mode = brk_mode;
    end else begin
      rs_act  = fs_act;
      rs_mode = fs_mode;
    end

    act      = csvtok_pkg::ACT_NONE;
    comm     = 1'b0;
    mode_nxt = mode_r;
    if (s1_cmd_r) begin
      // End-of-input flush closes any open row.
      mode_nxt = csvtok_pkg::M_ROW_START;
      unique case (mode_r)
        csvtok_pkg::M_FIELD_START,
        csvtok_pkg::M_PLAIN,
        csvtok_pkg::M_QUOTED,
        csvtok_pkg::M_QUOTE_SEEN: act = csvtok_pkg::ACT_ROW;
        csvtok_pkg::M_COMMENT: begin
          act  = csvtok_pkg::ACT_ROW;
          comm = 1'b1;
        end
        default: act = csvtok_pkg::ACT_NONE;
      endcase
    end else begin
      unique case (mode_r)
        csvtok_pkg::M_AFTER_CR: begin
          if (s1_cu_r == csvtok_pkg::CH_LF) begin
            mode_nxt = csvtok_pkg::M_ROW_START;
          end else begin
            act      = rs_act;
            mode_nxt = rs_mode;
            comm     = rs_comm;
          end
        end
        csvtok_pkg::M_FIELD_START: begin
          act      = fs_act;
          mode_nxt = fs_mode;
        end
        csvtok_pkg::M_PLAIN: begin
          act      = pl_act;
          mode_nxt = pl_mode;
        end
        csvtok_pkg::M_QUOTED: begin
          if (is_q) begin
            mode_nxt = csvtok_pkg::M_QUOTE_SEEN;
          end else begin
            act = csvtok_pkg::ACT_DATA;
          end
        end
        csvtok_pkg::M_QUOTE_SEEN: begin
          if (is_q) begin
            act      = csvtok_pkg::ACT_DATA;
            mode_nxt = csvtok_pkg::M_QUOTED;
          end else begin
            act      = pl_act;
            mode_nxt = pl_mode;
          end
        end
        csvtok_pkg::M_COMMENT: begin
          comm = 1'b1;
          if (is_brk) begin
            act      = csvtok_pkg::ACT_ROW;
            mode_nxt = brk_mode;
          end else begin
            act = csvtok_pkg::ACT_DATA;
          end
        end
        default: begin
          act      = rs_act;
          mode_nxt = rs_mode;
          comm     = rs_comm;
        end
      endcase
    end

    // Saturating cell count and the row maximum a row end would report.
    cnt_inc = (cnt_r < CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    col_row = (comm || (cnt_inc <= col_r)) ? col_r : cnt_inc;

    r0.kind      = csvtok_pkg::KIND_DATA;
    r0.data_char = '0;
    r0.comment   = comm;
    r0.cells     = '0;
    r0.max_cols  = csvtok_pkg::CNT_OUT_W'(col_r);
    r0.last      = 1'b1;
    r1.kind      = csvtok_pkg::KIND_ROW_END;
    r1.data_char = '0;
    r1.comment   = comm;
    r1.cells     = csvtok_pkg::CNT_OUT_W'(cnt_inc);
    r1.max_cols  = csvtok_pkg::CNT_OUT_W'(col_row);
    r1.last      = 1'b1;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    n_res        = 2'd0;

    unique case (act)
      csvtok_pkg::ACT_DATA: begin
        n_res        = 2'd1;
        r0.data_char = s1_cu_r;
      end
      csvtok_pkg::ACT_FIELD: begin
        n_res   = 2'd1;
        r0.kind = csvtok_pkg::KIND_FIELD_END;
        cnt_nxt = cnt_inc;
      end
      csvtok_pkg::ACT_ROW: begin
        n_res   = 2'd2;
        r0.kind = csvtok_pkg::KIND_FIELD_END;
        r0.last = 1'b0;
        cnt_nxt = '0;
        col_nxt = col_row;
      end
      default: n_res = 2'd0;
    endcase

    // A flush starts a new text.
    if (s1_cmd_r) begin
      cnt_nxt = '0;
      col_nxt = '0;
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csvtok_pkg::M_ROW_START;
      cnt_r  <= '0;
      col_r  <= '0;
    end else if (s1_adv) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      col_r  <= col_nxt;
    end
  end

  // Output buffer: a pair from one item, shifted out one transaction a cycle while the receiver is ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (s1_adv) begin
      ob_cnt_r <= n_res;
    end else if (out_take) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ob0_r <= r0;
      ob1_r <= r1;
    end else if (out_take) begin
      ob0_r <= ob1_r;
    end
  end

  // Result port packing.
  assign out_tdata = {4'b0000, ob0_r.max_cols, ob0_r.cells, ob0_r.data_char};
  assign out_tuser = {ob0_r.comment, ob0_r.kind};
  assign out_tlast = ob0_r.last;

`ifndef SYNTHESIS
  // The first of a pair never closes the item, and the second is always a row end.
  a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r == 2'd2) |-> !ob0_r.last)
    else $error("first result of a pair marked last");

  a_pair_second_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r == 2'd2) |-> (ob1_r.kind == csvtok_pkg::KIND_ROW_END))
    else $error("second result of a pair is not a row end");

  // A stalled pair stays whole.
  a_pair_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((ob_cnt_r == 2'd2) && !out_tready) |=> (ob_cnt_r == 2'd2))
    else $error("pending pair lost while stalled");

  // The running maximum only falls on a flush.
  a_col_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_cmd_r) |=> (col_r >= $past(col_r)))
    else $error("column maximum decreased without a flush");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking stream testbench for the CSV field tokenizer core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned COL_LIMIT     = csvtok_pkg::MAX_COLUMNS_DEF;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          CYCLE_LIMIT   = 400000;

  // One entry of the stimulus list: a code unit or flush, a register write,
  // or a pause until every expected event has come out.
  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_DRAIN
  } stim_op_t;

  typedef struct packed {
    stim_op_t             op;
    logic                 cmd;
    logic [15:0]          cu;
    csvtok_pkg::cfg_idx_t idx;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;  // [15:0] code_unit
  logic        in_tuser = 1'b0;      // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;            // [15:0] data_char, [25:16] cells_in_row,
                                     // [35:26] max_columns, [39:36] zero
  logic [2:0]  out_tuser;            // [1:0] kind, [2] comment_row
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = csvtok_pkg::CFG_DELIMITER;
  logic [15:0] cfg_data = 16'h0000;

  stim_t              stim_q[$];
  csvtok_pkg::res_t   pending_events[$];
  csvtok_pkg::res_t   unit_events[$];

  // Tokenizer state and registers as the testbench tracks them.
  csvtok_pkg::mode_t  pmode = csvtok_pkg::M_ROW_START;
  int unsigned row_cells = 0;
  int unsigned col_max = 0;
  logic [15:0] cf_delim = csvtok_pkg::DELIMITER_RST;
  logic        cf_cmt_en = 1'b0;
  logic [15:0] cf_cmt_char = csvtok_pkg::COMMENT_CHAR_RST;

  // Register values that the stimulus generator assumes.
  logic [15:0] gen_delim = csvtok_pkg::DELIMITER_RST;
  logic        gen_cmt_en = 1'b0;
  logic [15:0] gen_cmt = csvtok_pkg::COMMENT_CHAR_RST;
  int          queued_units = 0;

  int          units_sent = 0;
  int          settle_cnt = 0;
  int          stall_left = 0;
  logic        stall_done = 1'b0;
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  logic        calm;

  csv_field_tokenizer_core #(
    .MAX_COLUMNS(COL_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Neither side idles during this window.
  assign calm = (cycle_cnt >= 1000) && (cycle_cnt < 1800);

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------

  function automatic void emit(csvtok_pkg::kind_t k, logic [15:0] ch, logic cm,
                               logic [9:0] cells);
    csvtok_pkg::res_t r;
    r.kind      = k;
    r.data_char = ch;
    r.comment   = cm;
    r.cells     = cells;
    r.max_cols  = 10'(col_max);
    r.last      = 1'b0;
    unit_events.insert(unit_events.size(), r);
  endfunction

  function automatic void field_done(logic cm);
    if (row_cells < COL_LIMIT) row_cells++;
    emit(csvtok_pkg::KIND_FIELD_END, 16'h0000, cm, 10'd0);
  endfunction

  // A data row updates the column maximum before its row-end event goes out.
  function automatic void row_done(logic cm);
    if (!cm && row_cells > col_max) col_max = row_cells;
    emit(csvtok_pkg::KIND_ROW_END, 16'h0000, cm, 10'(row_cells));
    row_cells = 0;
  endfunction

  function automatic void close_row(logic [15:0] c, logic cm);
    field_done(cm);
    row_done(cm);
    pmode = (c == csvtok_pkg::CH_CR) ? csvtok_pkg::M_AFTER_CR : csvtok_pkg::M_ROW_START;
  endfunction

  function automatic void plain_unit(logic [15:0] c);
    if (c == cf_delim) begin
      field_done(1'b0);
      pmode = csvtok_pkg::M_FIELD_START;
    end else if (c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF) begin
      close_row(c, 1'b0);
    end else begin
      emit(csvtok_pkg::KIND_DATA, c, 1'b0, 10'd0);
      pmode = csvtok_pkg::M_PLAIN;
    end
  endfunction

  function automatic void field_start_unit(logic [15:0] c);
    if (c == csvtok_pkg::CH_QUOTE) pmode = csvtok_pkg::M_QUOTED;
    else plain_unit(c);
  endfunction

  // Comment check first; a line break that is neither quote nor delimiter is a blank line.
  function automatic void row_start_unit(logic [15:0] c);
    if (cf_cmt_en && c == cf_cmt_char) begin
      pmode = csvtok_pkg::M_COMMENT;
      emit(csvtok_pkg::KIND_DATA, c, 1'b1, 10'd0);
    end else if (c != csvtok_pkg::CH_QUOTE && c != cf_delim &&
                 (c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF)) begin
      pmode = (c == csvtok_pkg::CH_CR) ? csvtok_pkg::M_AFTER_CR : csvtok_pkg::M_ROW_START;
    end else begin
      field_start_unit(c);
    end
  endfunction

  // Works out the events of one accepted input and queues them in order.
  function automatic void tokenize_unit(logic cmd, logic [15:0] c);
    csvtok_pkg::res_t r;
    unit_events.delete();
    if (cmd) begin
      case (pmode)
        csvtok_pkg::M_FIELD_START, csvtok_pkg::M_PLAIN,
        csvtok_pkg::M_QUOTED, csvtok_pkg::M_QUOTE_SEEN: close_row(16'h0000, 1'b0);
        csvtok_pkg::M_COMMENT: close_row(16'h0000, 1'b1);
        default: ;
      endcase
      pmode     = csvtok_pkg::M_ROW_START;
      row_cells = 0;
      col_max   = 0;
    end else begin
      case (pmode)
        csvtok_pkg::M_AFTER_CR: begin
          if (c == csvtok_pkg::CH_LF) pmode = csvtok_pkg::M_ROW_START;
          else row_start_unit(c);
        end
        csvtok_pkg::M_FIELD_START: field_start_unit(c);
        csvtok_pkg::M_PLAIN: plain_unit(c);
        csvtok_pkg::M_QUOTED: begin
          if (c == csvtok_pkg::CH_QUOTE) pmode = csvtok_pkg::M_QUOTE_SEEN;
          else emit(csvtok_pkg::KIND_DATA, c, 1'b0, 10'd0);
        end
        csvtok_pkg::M_QUOTE_SEEN: begin
          if (c == csvtok_pkg::CH_QUOTE) begin
            emit(csvtok_pkg::KIND_DATA, c, 1'b0, 10'd0);
            pmode = csvtok_pkg::M_QUOTED;
          end else begin
            plain_unit(c);
          end
        end
        csvtok_pkg::M_COMMENT: begin
          if (c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF) close_row(c, 1'b1);
          else emit(csvtok_pkg::KIND_DATA, c, 1'b1, 10'd0);
        end
        default: row_start_unit(c);
      endcase
    end
    foreach (unit_events[i]) begin
      r = unit_events[i];
      r.last = (i == unit_events.size() - 1);
      pending_events.insert(pending_events.size(), r);
    end
  endfunction

  function automatic void apply_cfg(csvtok_pkg::cfg_idx_t idx, logic [15:0] d);
    case (idx)
      csvtok_pkg::CFG_DELIMITER:    cf_delim = d;
      csvtok_pkg::CFG_COMMENT_EN:   cf_cmt_en = d[0];
      csvtok_pkg::CFG_COMMENT_CHAR: cf_cmt_char = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus list construction
  // ---------------------------------------------------------------------------

  task automatic add_unit(logic [15:0] c);
    stim_t s;
    s.op  = OP_ITEM;
    s.cmd = 1'b0;
    s.cu  = c;
    s.idx = csvtok_pkg::CFG_DELIMITER;
    stim_q.insert(stim_q.size(), s);
    queued_units++;
  endtask

  // The code unit of a flush carries random bits that the block must ignore.
  task automatic add_flush();
    stim_t s;
    s.op  = OP_ITEM;
    s.cmd = 1'b1;
    s.cu  = 16'($urandom_range(16'hFFFF));
    s.idx = csvtok_pkg::CFG_DELIMITER;
    stim_q.insert(stim_q.size(), s);
    queued_units++;
  endtask

  task automatic add_cfg(csvtok_pkg::cfg_idx_t idx, logic [15:0] d);
    stim_t s;
    s.op  = OP_CFG;
    s.cmd = 1'b0;
    s.cu  = d;
    s.idx = idx;
    stim_q.insert(stim_q.size(), s);
  endtask

  // Registers change only once the block has emptied and settled.
  task automatic set_config(logic [15:0] delim, logic en, logic [15:0] cmt);
    stim_t s;
    s.op  = OP_DRAIN;
    s.cmd = 1'b0;
    s.cu  = 16'h0000;
    s.idx = csvtok_pkg::CFG_DELIMITER;
    stim_q.insert(stim_q.size(), s);
    add_cfg(csvtok_pkg::CFG_DELIMITER, delim);
    add_cfg(csvtok_pkg::CFG_COMMENT_EN, {15'h0000, en});
    add_cfg(csvtok_pkg::CFG_COMMENT_CHAR, cmt);
    gen_delim  = delim;
    gen_cmt_en = en;
    gen_cmt    = cmt;
  endtask

  function automatic logic [15:0] text_unit();
    if ($urandom_range(99) < 80) return 16'(16'h0061 + $urandom_range(25));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [15:0] noise_unit();
    case ($urandom_range(6))
      0: return csvtok_pkg::CH_QUOTE;
      1: return csvtok_pkg::CH_CR;
      2: return csvtok_pkg::CH_LF;
      3: return gen_delim;
      4: return gen_cmt;
      5: return 16'(16'h0041 + $urandom_range(25));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic add_plain();
    repeat ($urandom_range(4)) add_unit(text_unit());
  endtask

  // Quoted cell with embedded delimiters, breaks and doubled quotes.
  task automatic add_quoted();
    add_unit(csvtok_pkg::CH_QUOTE);
    repeat ($urandom_range(5)) begin
      case ($urandom_range(5))
        0: add_unit(gen_delim);
        1: add_unit($urandom_range(1) ? csvtok_pkg::CH_CR : csvtok_pkg::CH_LF);
        2: begin
          add_unit(csvtok_pkg::CH_QUOTE);
          add_unit(csvtok_pkg::CH_QUOTE);
        end
        default: add_unit(text_unit());
      endcase
    end
    add_unit(csvtok_pkg::CH_QUOTE);
    if ($urandom_range(7) == 0) add_unit(text_unit());
  endtask

  // One well-formed row or comment line with a random line ending.
  task automatic add_row();
    int nf;
    int f;
    if (gen_cmt_en && $urandom_range(9) == 0) begin
      add_unit(gen_cmt);
      repeat ($urandom_range(6)) add_unit(text_unit());
    end else begin
      nf = $urandom_range(1, 5);
      for (f = 0; f < nf; f++) begin
        if (f > 0) add_unit(gen_delim);
        if ($urandom_range(3) == 0) add_quoted();
        else add_plain();
      end
    end
    case ($urandom_range(3))
      0: add_unit(csvtok_pkg::CH_CR);
      1: add_unit(csvtok_pkg::CH_LF);
      default: begin
        add_unit(csvtok_pkg::CH_CR);
        add_unit(csvtok_pkg::CH_LF);
      end
    endcase
    if ($urandom_range(7) == 0)
      add_unit($urandom_range(1) ? csvtok_pkg::CH_CR : csvtok_pkg::CH_LF);
  endtask

  task automatic random_phase(int target);
    int stop;
    int r;
    stop = queued_units + target;
    while (queued_units < stop) begin
      r = $urandom_range(99);
      if (r < 80) begin
        add_row();
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) add_unit(noise_unit());
      end else if (r < 95) begin
        add_flush();
      end else begin
        add_plain();
        add_flush();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input and configuration driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_proc
    logic  in_next;
    logic  cfg_next;
    stim_t s;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= 16'h0000;
      in_tuser    <= 1'b0;
      cfg_valid   <= 1'b0;
      cfg_index   <= csvtok_pkg::CFG_DELIMITER;
      cfg_data    <= 16'h0000;
      pmode       = csvtok_pkg::M_ROW_START;
      row_cells   = 0;
      col_max     = 0;
      cf_delim    = csvtok_pkg::DELIMITER_RST;
      cf_cmt_en   = 1'b0;
      cf_cmt_char = csvtok_pkg::COMMENT_CHAR_RST;
      settle_cnt  = 0;
    end else begin
      in_next  = in_tvalid && !in_tready;
      cfg_next = cfg_valid && !cfg_ready;
      if (in_tvalid && in_tready) begin
        tokenize_unit(in_tuser, in_tdata);
        units_sent <= units_sent + 1;
      end
      if (cfg_valid && cfg_ready) apply_cfg(csvtok_pkg::cfg_idx_t'(cfg_index), cfg_data);

      // Pick up the next stimulus entry once nothing is on offer.
      if (settle_cnt != 0) begin
        settle_cnt--;
      end else if (!in_next && !cfg_next && stim_q.size() != 0) begin
        s = stim_q[0];
        case (s.op)
          OP_ITEM: begin
            if (calm || $urandom_range(99) >= 13) begin
              s = stim_q.pop_front();
              in_tdata <= s.cu;
              in_tuser <= s.cmd;
              in_next  = 1'b1;
            end
          end
          OP_CFG: begin
            s = stim_q.pop_front();
            cfg_index <= s.idx;
            cfg_data  <= s.cu;
            cfg_next  = 1'b1;
          end
          default: begin
            if (pending_events.size() == 0) begin
              s = stim_q.pop_front();
              settle_cnt = SETTLE_CYCLES;
            end
          end
        endcase
      end
      in_tvalid <= in_next;
      cfg_valid <= cfg_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure and result checking
  // ---------------------------------------------------------------------------

  // One long hold-off on the result side once the random text is under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && units_sent >= 400) begin
      stall_left <= 120;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : check_proc
    csvtok_pkg::res_t want;
    csvtok_pkg::res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind      = csvtok_pkg::kind_t'(out_tuser[1:0]);
        got.data_char = out_tdata[15:0];
        got.comment   = out_tuser[2];
        got.cells     = out_tdata[25:16];
        got.max_cols  = out_tdata[35:26];
        got.last      = out_tlast;
        if (pending_events.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected event kind=%0d char=%h cm=%b cells=%0d max=%0d last=%b",
                     $realtime, got.kind, got.data_char, got.comment, got.cells,
                     got.max_cols, got.last);
        end else begin
          want = pending_events.pop_front();
          if (got !== want || out_tdata[39:36] !== 4'h0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: event mismatch", $realtime);
              $display("  expected kind=%0d char=%h cm=%b cells=%0d max=%0d last=%b pad=0",
                       want.kind, want.data_char, want.comment, want.cells,
                       want.max_cols, want.last);
              $display("  actual   kind=%0d char=%h cm=%b cells=%0d max=%0d last=%b pad=%h",
                       got.kind, got.data_char, got.comment, got.cells,
                       got.max_cols, got.last, out_tdata[39:36]);
            end
          end
        end
      end
      out_tready <= (stall_left == 0) && (calm || $urandom_range(99) >= 13);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Directed text on the reset register values.
    // Quoted cell: doubled quote, embedded delimiter and break, text after closing quote.
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(16'("a"));
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(16'(","));
    add_unit(csvtok_pkg::CH_LF);
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(16'("x"));
    // Plain cells at both ends of the code unit range, ended by CRLF.
    add_unit(16'(","));
    add_unit(16'hFFFF);
    add_unit(16'(","));
    add_unit(16'h0000);
    add_unit(csvtok_pkg::CH_CR);
    add_unit(csvtok_pkg::CH_LF);
    // Blank lines are dropped.
    add_unit(csvtok_pkg::CH_LF);
    add_unit(csvtok_pkg::CH_CR);
    add_unit(csvtok_pkg::CH_CR);
    // A row holding only an empty quoted cell.
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(csvtok_pkg::CH_LF);
    // Quote inside a plain cell, then an unterminated quote closed by a flush.
    add_unit(16'("b"));
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(16'(","));
    add_unit(csvtok_pkg::CH_QUOTE);
    add_unit(16'("z"));
    add_flush();
    add_flush();

    // Delimiter is CR and LF opens comments: the comment check wins at row start,
    // the LF after CR is swallowed, and CR acts as a delimiter.
    set_config(csvtok_pkg::CH_CR, 1'b1, csvtok_pkg::CH_LF);
    add_unit(csvtok_pkg::CH_LF);
    add_unit(16'("q"));
    add_unit(csvtok_pkg::CH_CR);
    add_unit(csvtok_pkg::CH_LF);
    add_unit(csvtok_pkg::CH_CR);
    add_unit(16'("a"));
    add_unit(csvtok_pkg::CH_LF);
    add_unit(csvtok_pkg::CH_LF);
    add_unit(16'("w"));
    add_flush();

    // Random text over several register settings, extremes included.
    set_config(16'(","), 1'b1, 16'("#"));
    random_phase(50);
    // One row wide enough to saturate both cell counters.
    repeat (1030) add_unit(gen_delim);
    add_unit(csvtok_pkg::CH_LF);
    random_phase(30);
    set_config(16'(";"), 1'b0, 16'("#"));
    random_phase(40);
    set_config(16'h0000, 1'b1, 16'hFFFF);
    random_phase(40);
    set_config(16'hFFFF, 1'b1, 16'h0000);
    random_phase(40);
    set_config(16'h0009, 1'b1, csvtok_pkg::CH_QUOTE);
    random_phase(40);
    set_config(csvtok_pkg::CH_QUOTE, 1'b0, 16'("!"));
    random_phase(40);
    set_config(csvtok_pkg::CH_LF, 1'b1, csvtok_pkg::CH_CR);
    random_phase(40);

    // Reset, then release at a clock edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stimulus to go in and every expected event to come out.
    while (stim_q.size() != 0 || in_tvalid || cfg_valid || settle_cnt != 0)
      @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0 && pending_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/csvtok_pkg.sv
hdl/csv_field_tokenizer_core.sv
bench/tb_top.sv
